FILE: sv/swsd_pkg.sv
// Shared constants for the sliding-window spread detector.
// No dependencies; used by sliding_window_spread_detector_unit.
`timescale 1ns / 1ps

package swsd_pkg;

  // default sizes
  localparam int MAX_WINDOW_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_SPREAD    = 1'd1;

  // fixed field widths
  localparam int WINDOW_LENGTH_W = 7;
  localparam int MAX_SPREAD_W    = 16;
  localparam int SAMPLE_PORT_W   = 16;
  localparam int POSITION_W      = 32;

  // queue select
  localparam logic QSEL_MIN = 1'b0;
  localparam logic QSEL_MAX = 1'b1;

endpackage

FILE: sv/swsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module swsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/sliding_window_spread_detector_unit.sv
// Sliding-window spread detector, top level.
// Depends on swsd_pkg and swsd_ram.
`timescale 1ns / 1ps

// Takes one sample word per handshake and tracks the minimum and maximum of the
// last window_length samples with two monotonic queues, each kept as a circular
// buffer in its own RAM. Once a full window is seen, each window whose spread
// (max - min) is at most max_spread gives one result word with the 1-based start
// position of that window (wraps modulo 2^32). On the word flagged last_sample,
// if no window of the stream matched, a no-match word is given instead, and all
// stream state is cleared; the registers keep their values. window_length of 0
// acts as 1, values above MAX_WINDOW act as MAX_WINDOW. Sequencing: one small
// sequencer drives a single shared compare unit over both queues, min first,
// then max. A word is accepted; then, per queue, the head entry is read and
// checked and dropped while it has expired, the tail entry is read and checked
// and dropped while the new value makes it redundant, and the new entry is pushed;
// an empty queue skips its checks. Last, both fronts are read and the spread is
// checked. As RAM read data is registered, each queue probe is a read state then
// a check state. in_stall is high while a word is in work. A result sits in
// the output register, so the next sample can be accepted while it waits; a word
// whose result finds that register still held by a stalled receiver stays in its
// front check until the receiver takes the old one. Queue RAMs need no clearing
// pass: per-queue head pointers and counts define which entries are live.
module sliding_window_spread_detector_unit #(
  parameter int MAX_WINDOW   = swsd_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = swsd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_write_en,
  input  logic [swsd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [swsd_pkg::CFG_DATA_W-1:0]        cfg_data,
  // sample channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [swsd_pkg::SAMPLE_PORT_W-1:0]     sample,
  input  logic                                   last_sample,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   match_found,
  output logic [swsd_pkg::POSITION_W-1:0]        window_start,
  output logic                                   no_match_in_stream
);

  localparam int IW   = $clog2(MAX_WINDOW);        // slot index
  localparam int CW   = $clog2(MAX_WINDOW + 1);    // entry count
  localparam int LW   = $clog2(MAX_WINDOW + 1);    // effective window length
  localparam int PW   = $clog2(MAX_WINDOW) + 1;    // stored position (mod 2^PW)
  localparam int SW   = SAMPLE_WIDTH;
  localparam int EW   = SW + PW;                   // entry = {value, position}
  localparam int CMPW0 = (SW > PW) ? SW : PW;
  localparam int CMPW = (CMPW0 > swsd_pkg::MAX_SPREAD_W) ? CMPW0 : swsd_pkg::MAX_SPREAD_W;
  localparam int PSW  = swsd_pkg::POSITION_W;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_HEAD_RD   = 8'b0000_0010,
    S_HEAD_CHK  = 8'b0000_0100,
    S_TAIL_RD   = 8'b0000_1000,
    S_TAIL_CHK  = 8'b0001_0000,
    S_PUSH      = 8'b0010_0000,
    S_FRONT_RD  = 8'b0100_0000,
    S_FRONT_CHK = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // registers
  logic [swsd_pkg::WINDOW_LENGTH_W-1:0] window_length;
  logic [swsd_pkg::MAX_SPREAD_W-1:0]    max_spread;

  // stream state
  logic [IW-1:0]  head [2];
  logic [CW-1:0]  count [2];
  logic [PSW-1:0] sample_counter;
  logic           match_seen;

  // latched word
  logic [SW-1:0]  cur_value;
  logic           cur_last;
  logic [LW-1:0]  cur_len;
  logic           qsel;

  // effective length from the register
  logic [LW-1:0] len_eff;
  always_comb begin
    if (window_length == '0) begin
      len_eff = LW'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      len_eff = LW'(MAX_WINDOW);
    end else begin
      len_eff = LW'(window_length);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= swsd_pkg::WINDOW_LENGTH_W'(1);
      max_spread    <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        swsd_pkg::REG_WINDOW_LENGTH:
          window_length <= cfg_data[swsd_pkg::WINDOW_LENGTH_W-1:0];
        swsd_pkg::REG_MAX_SPREAD:
          max_spread <= cfg_data[swsd_pkg::MAX_SPREAD_W-1:0];
        default: ;
      endcase
    end
  end

  // current queue pointers
  logic [IW-1:0] cur_head;
  logic [CW-1:0] cur_count;
  logic [IW-1:0] head_inc;
  logic [IW:0]   tail_sum;
  logic [IW:0]   push_sum;
  logic [IW-1:0] tail_idx;
  logic [IW-1:0] push_idx;
  logic          cur_full;

  assign cur_head  = head[qsel];
  assign cur_count = count[qsel];
  assign head_inc  = (cur_head == IW'(MAX_WINDOW - 1)) ? '0 : cur_head + IW'(1);
  assign cur_full  = (cur_count >= CW'(MAX_WINDOW));

  always_comb begin
    tail_sum = (IW+1)'(cur_head) + (IW+1)'(cur_count) - (IW+1)'(1);
    if (tail_sum >= (IW+1)'(MAX_WINDOW)) begin
      tail_sum = tail_sum - (IW+1)'(MAX_WINDOW);
    end
    push_sum = (IW+1)'(cur_head) + (IW+1)'(cur_count);
    if (push_sum >= (IW+1)'(MAX_WINDOW)) begin
      push_sum = push_sum - (IW+1)'(MAX_WINDOW);
    end
  end
  assign tail_idx = tail_sum[IW-1:0];
  assign push_idx = push_sum[IW-1:0];

  // queue RAMs, one per queue
  logic          ram_we [2];
  logic [IW-1:0] ram_raddr [2];
  logic [EW-1:0] ram_rdata [2];
  logic [IW-1:0] rd_idx;
  logic [EW-1:0] push_entry;

  assign rd_idx     = (state == S_TAIL_RD) ? tail_idx : cur_head;
  assign push_entry = {cur_value, sample_counter[PW-1:0]};

  for (genvar q = 0; q < 2; q++) begin : g_queue
    assign ram_we[q]    = (state == S_PUSH) && (qsel == 1'(q));
    // both fronts stay on the read port while the final check waits
    assign ram_raddr[q] = (state == S_FRONT_RD || state == S_FRONT_CHK) ? head[q] : rd_idx;

    swsd_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_WINDOW)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[q]),
      .waddr (push_idx),
      .wdata (push_entry),
      .raddr (ram_raddr[q]),
      .rdata (ram_rdata[q])
    );
  end

  // entry fields of the probed queue
  logic [SW-1:0] probe_value;
  logic [PW-1:0] probe_pos;
  logic [PW-1:0] probe_age;
  assign probe_value = ram_rdata[qsel][EW-1:PW];
  assign probe_pos   = ram_rdata[qsel][PW-1:0];
  assign probe_age   = sample_counter[PW-1:0] - probe_pos;

  // front values for the spread check
  logic [SW-1:0] lo_value;
  logic [SW-1:0] hi_value;
  logic [SW-1:0] spread;
  assign lo_value = ram_rdata[swsd_pkg::QSEL_MIN][EW-1:PW];
  assign hi_value = ram_rdata[swsd_pkg::QSEL_MAX][EW-1:PW];
  assign spread   = (hi_value >= lo_value) ? (hi_value - lo_value) : '0;

  // shared compare unit: cmp_a >= cmp_b
  logic [CMPW-1:0] cmp_a;
  logic [CMPW-1:0] cmp_b;
  logic            cmp_ge;
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state)
      S_HEAD_CHK: begin
        // expired when age >= len
        cmp_a = CMPW'(probe_age);
        cmp_b = CMPW'(cur_len);
      end
      S_TAIL_CHK: begin
        // min queue drops tail >= v, max queue drops tail <= v
        if (qsel == swsd_pkg::QSEL_MIN) begin
          cmp_a = CMPW'(probe_value);
          cmp_b = CMPW'(cur_value);
        end else begin
          cmp_a = CMPW'(cur_value);
          cmp_b = CMPW'(probe_value);
        end
      end
      S_FRONT_CHK: begin
        cmp_a = CMPW'(max_spread);
        cmp_b = CMPW'(spread);
      end
      default: ;
    endcase
  end
  assign cmp_ge = (cmp_a >= cmp_b);

  // result decision
  logic           win_full;
  logic           hit;
  logic           no_match;
  logic           have_result;
  logic           out_busy;
  logic [PSW-1:0] start_pos;
  assign win_full    = (sample_counter >= PSW'(cur_len) - PSW'(1));
  assign hit         = win_full && cmp_ge;
  assign no_match    = cur_last && !match_seen && !hit;
  assign have_result = hit || no_match;
  assign out_busy    = out_valid && out_stall;
  assign start_pos   = sample_counter - PSW'(cur_len) + PSW'(2);

  assign in_stall = (state != S_IDLE);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_valid) state_next = S_HEAD_RD;
      S_HEAD_RD:   state_next = (cur_count == '0) ? S_TAIL_RD : S_HEAD_CHK;
      S_HEAD_CHK:  state_next = cmp_ge ? S_HEAD_RD : S_TAIL_RD;
      S_TAIL_RD:   state_next = (cur_count == '0) ? S_PUSH : S_TAIL_CHK;
      S_TAIL_CHK:  state_next = cmp_ge ? S_TAIL_RD : S_PUSH;
      S_PUSH:      state_next = (qsel == swsd_pkg::QSEL_MAX) ? S_FRONT_RD : S_HEAD_RD;
      S_FRONT_RD:  state_next = S_FRONT_CHK;
      S_FRONT_CHK: if (!(have_result && out_busy)) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      head           <= '{default: '0};
      count          <= '{default: '0};
      sample_counter <= '0;
      match_seen     <= 1'b0;
      qsel           <= swsd_pkg::QSEL_MIN;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;

      if (state == S_FRONT_CHK && have_result && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            qsel <= swsd_pkg::QSEL_MIN;
          end
        end
        S_HEAD_CHK: begin
          if (cmp_ge) begin
            head[qsel]  <= head_inc;
            count[qsel] <= cur_count - CW'(1);
          end
        end
        S_TAIL_CHK: begin
          if (cmp_ge) begin
            count[qsel] <= cur_count - CW'(1);
          end
        end
        S_PUSH: begin
          // full guard: the new entry lands on the oldest slot
          if (cur_full) begin
            head[qsel] <= head_inc;
          end else begin
            count[qsel] <= cur_count + CW'(1);
          end
          qsel <= swsd_pkg::QSEL_MAX;
        end
        S_FRONT_CHK: begin
          if (!(have_result && out_busy)) begin
            if (cur_last) begin
              head           <= '{default: '0};
              count          <= '{default: '0};
              sample_counter <= '0;
              match_seen     <= 1'b0;
            end else begin
              sample_counter <= sample_counter + PSW'(1);
              if (hit) begin
                match_seen <= 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cur_value <= SW'(sample);
      cur_last  <= last_sample;
      cur_len   <= len_eff;
    end
    if (state == S_FRONT_CHK && have_result && !out_busy) begin
      match_found        <= hit;
      window_start       <= hit ? start_pos : '0;
      no_match_in_stream <= no_match;
    end
  end

endmodule
